// ===== rtl/snt_pkg.sv =====
// Shared types, codes and the character classifier for the SVG number-list tokenizer.
// No dependencies; every module of the block imports this package.
package snt_pkg;

   // Default widths of the internal position and count state
   localparam int POSITION_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF    = 8;

   // Fixed widths of the payload fields
   localparam int POS_FIELD_BITS = 16;
   localparam int CNT_FIELD_BITS = 8;

   // Queue depths (powers of two)
   localparam int CMDQ_DEPTH = 2;
   localparam int RSPQ_DEPTH = 4;

   // Character codes of the grammar
   localparam logic [20:0] CH_ZERO   = 21'h30;
   localparam logic [20:0] CH_NINE   = 21'h39;
   localparam logic [20:0] CH_SPACE  = 21'h20;
   localparam logic [20:0] CH_TAB    = 21'h09;
   localparam logic [20:0] CH_LF     = 21'h0a;
   localparam logic [20:0] CH_CR     = 21'h0d;
   localparam logic [20:0] CH_MINUS  = 21'h2d;
   localparam logic [20:0] CH_PLUS   = 21'h2b;
   localparam logic [20:0] CH_POINT  = 21'h2e;
   localparam logic [20:0] CH_COMMA  = 21'h2c;
   localparam logic [20:0] CH_EXP_LO = 21'h65;
   localparam logic [20:0] CH_EXP_UP = 21'h45;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_CHAR  = 2'd1,
      CMD_END   = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_TOKEN = 2'd0,
      KIND_OK    = 2'd1,
      KIND_FAIL  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CC_DIGIT,
      CC_SPACE,
      CC_SIGN,
      CC_POINT,
      CC_COMMA,
      CC_EXP,
      CC_OTHER
   } char_class_type;

   typedef enum logic [3:0] {
      ST_OUT_NOCOMMA,
      ST_OUT_COMMA,
      ST_SIGN,
      ST_INT,
      ST_PT_AFTER_INT,
      ST_PT_LEAD,
      ST_FRAC,
      ST_EXP,
      ST_EXP_SIGN,
      ST_EXP_DIG
   } parse_state_type;

   // Input item
   typedef struct packed {
      logic [1:0]  command;
      logic [20:0] char_code;
      logic [15:0] start_position;
      logic [7:0]  count_wanted;
      logic        allow_leading_comma;
   } req_type;

   // Result item
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic [15:0] stop_position;
      logic [7:0]  numbers_found;
      logic        last;
   } rsp_type;

   // Classified item between front and back
   typedef struct packed {
      cmd_type        command;
      char_class_type cls;
      logic [15:0]    start_position;
      logic [7:0]     count_wanted;
      logic           allow_leading_comma;
   } cmdq_item_type;

   // Result queue write controls; wr1 only with wr0
   typedef struct packed {
      logic wr0;
      logic wr1;
   } rsp_wr_type;

   function automatic char_class_type classify(input logic [20:0] c);
      char_class_type cls;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         cls = CC_DIGIT;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
         cls = CC_SPACE;
      end else if (c == CH_MINUS || c == CH_PLUS) begin
         cls = CC_SIGN;
      end else if (c == CH_POINT) begin
         cls = CC_POINT;
      end else if (c == CH_COMMA) begin
         cls = CC_COMMA;
      end else if (c == CH_EXP_LO || c == CH_EXP_UP) begin
         cls = CC_EXP;
      end else begin
         cls = CC_OTHER;
      end
      return cls;
   endfunction

endpackage

// ===== rtl/snt_front.sv =====
// Front end: accepts input items, classifies characters, queues the classified items.
// Depends on snt_pkg.
module snt_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  snt_pkg::req_type       req_data,
   output logic                   q_valid,
   output snt_pkg::cmdq_item_type q_item,
   input  logic                   q_take
);
   import snt_pkg::*;

   localparam int PTR_BITS = $clog2(CMDQ_DEPTH);
   localparam int CNT_BITS = $clog2(CMDQ_DEPTH + 1);

   cmdq_item_type         slot_ff [CMDQ_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   cmdq_item_type         item;
   logic                  accept;
   logic                  wr_en;

   // Classify the incoming item
   always_comb begin
      item.command             = cmd_type'(req_data.command);
      item.cls                 = classify(req_data.char_code);
      item.start_position      = req_data.start_position;
      item.count_wanted        = req_data.count_wanted;
      item.allow_leading_comma = req_data.allow_leading_comma;
   end

   // Ignored commands are taken and dropped here
   assign full   = (count_ff == CNT_BITS'(CMDQ_DEPTH));
   assign accept = push && !full;
   assign wr_en  = accept && (item.command != CMD_NOP);

   assign q_valid = (count_ff != '0);
   assign q_item  = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_take) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_BITS'(wr_en) - CNT_BITS'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== rtl/snt_back.sv =====
// Back end: the number-list recognizer; turns classified items into result items.
// Depends on snt_pkg.
module snt_back #(
   parameter int POSITION_BITS = snt_pkg::POSITION_BITS_DEF,
   parameter int COUNT_BITS    = snt_pkg::COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  snt_pkg::cmdq_item_type q_item,
   output logic                   q_take,
   input  logic                   space2,
   output snt_pkg::rsp_wr_type    wr,
   output snt_pkg::rsp_type       wr_data0,
   output snt_pkg::rsp_type       wr_data1
);
   import snt_pkg::*;

   parse_state_type          st_ff, st_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] begin_ff, begin_in;
   logic                     open_ff, open_in;
   logic [COUNT_BITS-1:0]    found_ff, found_in;
   logic [COUNT_BITS-1:0]    wanted_ff, wanted_in;
   logic                     active_ff, active_in;
   logic                     any_ff, any_in;

   logic                     emit;
   logic                     fin;
   logic                     fin_ok;
   logic                     bad;
   logic                     stop;
   logic                     incomplete;
   logic                     last_wanted;
   logic [COUNT_BITS-1:0]    found_inc;
   rsp_type                  tok;
   rsp_type                  fin_item;

   assign q_take    = q_valid && space2;
   assign found_inc = found_ff + 1'b1;
   // found + 1 compared without wrap
   assign last_wanted = (({1'b0, found_ff} + {{COUNT_BITS{1'b0}}, 1'b1}) ==
                         {1'b0, wanted_ff});
   assign incomplete  = (st_ff == ST_SIGN) || (st_ff == ST_EXP) ||
                        (st_ff == ST_PT_LEAD) || (st_ff == ST_EXP_SIGN);

   // Next state of the recognizer and its decisions
   always_comb begin
      st_in     = st_ff;
      pos_in    = pos_ff;
      begin_in  = begin_ff;
      open_in   = open_ff;
      found_in  = found_ff;
      wanted_in = wanted_ff;
      active_in = active_ff;
      any_in    = any_ff;
      emit      = 1'b0;
      fin       = 1'b0;
      fin_ok    = 1'b0;
      bad       = 1'b0;
      stop      = 1'b0;

      if (q_take) begin
         unique case (q_item.command)
            CMD_START: begin
               pos_in    = POSITION_BITS'(q_item.start_position);
               wanted_in = COUNT_BITS'(q_item.count_wanted);
               st_in     = q_item.allow_leading_comma ? ST_OUT_COMMA : ST_OUT_NOCOMMA;
               begin_in  = '0;
               open_in   = 1'b0;
               found_in  = '0;
               any_in    = 1'b0;
               active_in = 1'b1;
            end
            CMD_CHAR: begin
               if (active_ff) begin
                  any_in = 1'b1;
                  unique case (st_ff)
                     ST_OUT_NOCOMMA, ST_OUT_COMMA: begin
                        if (q_item.cls == CC_SPACE) begin
                           st_in = st_ff;
                        end else if (q_item.cls == CC_COMMA && st_ff == ST_OUT_COMMA) begin
                           st_in = ST_OUT_NOCOMMA;
                        end else if (q_item.cls == CC_DIGIT) begin
                           open_in  = 1'b1;
                           begin_in = pos_ff;
                           st_in    = ST_INT;
                        end else if (q_item.cls == CC_SIGN) begin
                           open_in  = 1'b1;
                           begin_in = pos_ff;
                           st_in    = ST_SIGN;
                        end else if (q_item.cls == CC_POINT) begin
                           open_in  = 1'b1;
                           begin_in = pos_ff;
                           st_in    = ST_PT_LEAD;
                        end else begin
                           bad = 1'b1;
                        end
                     end
                     ST_SIGN: begin
                        if (q_item.cls == CC_DIGIT) begin
                           st_in = ST_INT;
                        end else if (q_item.cls == CC_POINT) begin
                           st_in = ST_PT_LEAD;
                        end else begin
                           bad = 1'b1;
                        end
                     end
                     ST_PT_LEAD: begin
                        if (q_item.cls == CC_DIGIT) begin
                           st_in = ST_FRAC;
                        end else begin
                           bad = 1'b1;
                        end
                     end
                     ST_EXP: begin
                        if (q_item.cls == CC_DIGIT) begin
                           st_in = ST_EXP_DIG;
                        end else if (q_item.cls == CC_SIGN) begin
                           st_in = ST_EXP_SIGN;
                        end else begin
                           bad = 1'b1;
                        end
                     end
                     ST_EXP_SIGN: begin
                        if (q_item.cls == CC_DIGIT) begin
                           st_in = ST_EXP_DIG;
                        end else begin
                           bad = 1'b1;
                        end
                     end
                     ST_INT, ST_PT_AFTER_INT, ST_FRAC, ST_EXP_DIG: begin
                        if (q_item.cls == CC_DIGIT) begin
                           if (st_ff == ST_PT_AFTER_INT) begin
                              st_in = ST_FRAC;
                           end
                        end else if (q_item.cls == CC_POINT && st_ff == ST_INT) begin
                           st_in = ST_PT_AFTER_INT;
                        end else if (q_item.cls == CC_EXP && st_ff != ST_EXP_DIG) begin
                           st_in = ST_EXP;
                        end else if (q_item.cls == CC_SPACE || q_item.cls == CC_COMMA) begin
                           // separator closes the token
                           emit     = 1'b1;
                           found_in = found_inc;
                           open_in  = 1'b0;
                           st_in    = (q_item.cls == CC_SPACE) ? ST_OUT_COMMA : ST_OUT_NOCOMMA;
                        end else if (q_item.cls == CC_SIGN || q_item.cls == CC_POINT) begin
                           // sign or second point splits and opens the next token
                           emit     = 1'b1;
                           found_in = found_inc;
                           begin_in = pos_ff;
                           st_in    = (q_item.cls == CC_SIGN) ? ST_SIGN : ST_PT_LEAD;
                        end else begin
                           bad = 1'b1;
                        end
                     end
                     default: begin
                        bad = 1'b1;
                     end
                  endcase

                  if (bad) begin
                     stop = 1'b1;
                  end else if (found_in == wanted_ff) begin
                     fin    = 1'b1;
                     fin_ok = 1'b1;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
               end
            end
            CMD_END: begin
               if (active_ff) begin
                  if (!any_ff) begin
                     fin    = 1'b1;
                     fin_ok = 1'b0;
                  end else begin
                     stop = 1'b1;
                  end
               end
            end
            default: begin
               st_in = st_ff;
            end
         endcase

         // Stop at an unfitting character or end of text
         if (stop) begin
            if (open_ff && last_wanted && !incomplete) begin
               emit     = 1'b1;
               found_in = found_inc;
               open_in  = 1'b0;
               fin      = 1'b1;
               fin_ok   = 1'b1;
            end else begin
               fin    = 1'b1;
               fin_ok = !open_ff && (found_ff == wanted_ff);
            end
         end

         if (fin) begin
            active_in = 1'b0;
         end
      end
   end

   // Result items
   always_comb begin
      tok.kind          = KIND_TOKEN;
      tok.token_start   = POS_FIELD_BITS'(begin_ff);
      tok.token_length  = POS_FIELD_BITS'(pos_ff - begin_ff);
      tok.stop_position = '0;
      tok.numbers_found = CNT_FIELD_BITS'(found_in);
      tok.last          = 1'b0;

      fin_item.kind          = fin_ok ? KIND_OK : KIND_FAIL;
      fin_item.token_start   = '0;
      fin_item.token_length  = '0;
      fin_item.stop_position = POS_FIELD_BITS'(pos_ff);
      fin_item.numbers_found = CNT_FIELD_BITS'(found_in);
      fin_item.last          = 1'b1;

      wr.wr0   = emit || fin;
      wr.wr1   = emit && fin;
      wr_data0 = emit ? tok : fin_item;
      wr_data1 = fin_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_OUT_NOCOMMA;
         pos_ff    <= '0;
         begin_ff  <= '0;
         open_ff   <= 1'b0;
         found_ff  <= '0;
         wanted_ff <= '0;
         active_ff <= 1'b0;
         any_ff    <= 1'b0;
      end else begin
         st_ff     <= st_in;
         pos_ff    <= pos_in;
         begin_ff  <= begin_in;
         open_ff   <= open_in;
         found_ff  <= found_in;
         wanted_ff <= wanted_in;
         active_ff <= active_in;
         any_ff    <= any_in;
      end
   end

endmodule

// ===== rtl/snt_rsp_fifo.sv =====
// Result queue: takes up to two result items per cycle, hands out one per transfer.
// Depends on snt_pkg.
module snt_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  snt_pkg::rsp_wr_type wr,
   input  snt_pkg::rsp_type    wr_data0,
   input  snt_pkg::rsp_type    wr_data1,
   output logic                space2,
   output logic                empty,
   input  logic                pop,
   output snt_pkg::rsp_type    rsp_data
);
   import snt_pkg::*;

   localparam int PTR_BITS = $clog2(RSPQ_DEPTH);
   localparam int CNT_BITS = $clog2(RSPQ_DEPTH + 1);

   rsp_type              slot_ff [RSPQ_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [PTR_BITS-1:0]  wr_ptr_next;
   logic                 rd_en;

   assign empty       = (count_ff == '0);
   assign rd_en       = pop && !empty;
   assign space2      = (count_ff <= CNT_BITS'(RSPQ_DEPTH - 2));
   assign rsp_data    = slot_ff[rd_ptr_ff];
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(wr.wr0) + PTR_BITS'(wr.wr1);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(rd_en);
      count_in  = count_ff + CNT_BITS'(wr.wr0) + CNT_BITS'(wr.wr1) - CNT_BITS'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, written at one or two consecutive slots
   always_ff @(posedge clock) begin
      if (wr.wr0) begin
         slot_ff[wr_ptr_ff] <= wr_data0;
      end
      if (wr.wr1) begin
         slot_ff[wr_ptr_next] <= wr_data1;
      end
   end

endmodule

// ===== rtl/svg_number_list_tokenizer.sv =====
// Top level of the SVG number-list tokenizer: front end, recognizer and result queue.
// Depends on snt_pkg, snt_front, snt_back and snt_rsp_fifo.
//
// Use: write input items with push while full is low. A start item opens a
// parse, character items step it, an end item closes it. Results are read
// from rsp_data while empty is low and taken with pop; each item gives zero,
// one or two results (a number token and/or the finish item, last = 1).
// Each item passes through the command queue and then the result queue before
// its results reach rsp_data. Throughput: one item per cycle, set by the
// recognizer update in the back end, as long as pop keeps up with the results.
// A two-entry command queue sits between the classifier and the recognizer;
// the recognizer takes an item only while the four-entry result queue has
// room for two results. When pop stays low the result queue fills, the
// command queue backs up and full rises; nothing is lost.
// Reset: both queues empty, no parse running, state as after power-up.
// Items sent while no parse runs give no result.
module svg_number_list_tokenizer #(
   parameter int POSITION_BITS = snt_pkg::POSITION_BITS_DEF,
   parameter int COUNT_BITS    = snt_pkg::COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  snt_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output snt_pkg::rsp_type rsp_data
);
   import snt_pkg::*;

   logic          q_valid;
   cmdq_item_type q_item;
   logic          q_take;
   logic          space2;
   rsp_wr_type    wr;
   rsp_type       wr_data0;
   rsp_type       wr_data1;

   // Classify and queue
   snt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_take   (q_take)
   );

   // Recognize
   snt_back #(
      .POSITION_BITS (POSITION_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_take   (q_take),
      .space2   (space2),
      .wr       (wr),
      .wr_data0 (wr_data0),
      .wr_data1 (wr_data1)
   );

   // Result queue
   snt_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .wr_data0 (wr_data0),
      .wr_data1 (wr_data1),
      .space2   (space2),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

// ===== sim/tb_svg_number_list_tokenizer.sv =====
// Self-checking testbench for the SVG number-list tokenizer: directed and random parses
// checked against a cycle-free parse predictor. Depends on snt_pkg and svg_number_list_tokenizer.
`timescale 1ns / 1ps

module tb_svg_number_list_tokenizer;
   import snt_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   svg_number_list_tokenizer dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   req_type text_items[$];    // items waiting to be offered
   rsp_type results_due[$];   // predicted tokens and finish items, oldest first

   int errors = 0;
   int sent_total = 0;
   int items_used = 0;        // items the parser acts on (ignored ones excluded)
   int results_seen = 0;
   int full_cycles = 0;
   int n_tokens = 0;
   int n_ok = 0;
   int n_fail = 0;

   // Predictor state
   parse_state_type st = ST_OUT_NOCOMMA;
   logic [15:0]     at_pos = '0;
   logic [15:0]     tok_begin = '0;
   logic            tok_open = 1'b0;
   logic [7:0]      found_n = '0;
   logic [7:0]      want_n = '0;
   logic            parsing = 1'b0;
   logic            got_char = 1'b0;

   // Queue one predicted result; numbers_found is the running count
   task automatic log_result(input kind_type kind, input logic [15:0] ts,
                             input logic [15:0] tl, input logic [15:0] sp);
      rsp_type r;
      r.kind = kind;
      r.token_start = ts;
      r.token_length = tl;
      r.stop_position = sp;
      r.numbers_found = found_n;
      r.last = (kind != KIND_TOKEN);
      results_due.push_back(r);
      if (kind == KIND_TOKEN) n_tokens++;
      else if (kind == KIND_OK) n_ok++;
      else n_fail++;
   endtask

   // Close the open token; it ends just before the current position
   task automatic close_token();
      found_n = found_n + 8'd1;
      log_result(KIND_TOKEN, tok_begin, at_pos - tok_begin, 16'd0);
   endtask

   task automatic end_parse(input bit ok);
      parsing = 1'b0;
      log_result(ok ? KIND_OK : KIND_FAIL, 16'd0, 16'd0, at_pos);
   endtask

   // Stop at an unfitting character or at end of text
   task automatic stop_parse();
      bit incomplete;
      incomplete = st inside {ST_SIGN, ST_EXP, ST_PT_LEAD, ST_EXP_SIGN};
      if (tok_open && int'(found_n) + 1 == int'(want_n) && !incomplete) begin
         close_token();
         tok_open = 1'b0;
         end_parse(1'b1);
      end else begin
         end_parse(!tok_open && found_n == want_n);
      end
   endtask

   // Predict the results of one accepted item
   task automatic tokenize(input req_type r);
      logic [20:0]     c;
      bit              dig, spc, sgn, pnt, cma, exm, bad;
      parse_state_type s;
      c = r.char_code;
      dig = c >= "0" && c <= "9";
      spc = c == " " || c == 21'h09 || c == 21'h0a || c == 21'h0d;
      sgn = c == "-" || c == "+";
      pnt = c == ".";
      cma = c == ",";
      exm = c == "e" || c == "E";
      bad = 1'b0;
      s = st;
      if (r.command == CMD_START) begin
         items_used++;
         at_pos = r.start_position;
         want_n = r.count_wanted;
         st = r.allow_leading_comma ? ST_OUT_COMMA : ST_OUT_NOCOMMA;
         tok_begin = '0;
         tok_open = 1'b0;
         found_n = '0;
         got_char = 1'b0;
         parsing = 1'b1;
      end else if (parsing && r.command == CMD_END) begin
         items_used++;
         if (!got_char) end_parse(1'b0);
         else stop_parse();
      end else if (parsing && r.command == CMD_CHAR) begin
         items_used++;
         got_char = 1'b1;
         case (s)
            ST_OUT_NOCOMMA, ST_OUT_COMMA: begin
               if (spc) begin
               end else if (cma && s == ST_OUT_COMMA) begin
                  st = ST_OUT_NOCOMMA;
               end else if (dig || sgn || pnt) begin
                  tok_open = 1'b1;
                  tok_begin = at_pos;
                  st = dig ? ST_INT : (sgn ? ST_SIGN : ST_PT_LEAD);
               end else begin
                  bad = 1'b1;
               end
            end
            ST_SIGN: begin
               if (dig) st = ST_INT;
               else if (pnt) st = ST_PT_LEAD;
               else bad = 1'b1;
            end
            ST_PT_LEAD: begin
               if (dig) st = ST_FRAC;
               else bad = 1'b1;
            end
            ST_EXP: begin
               if (dig) st = ST_EXP_DIG;
               else if (sgn) st = ST_EXP_SIGN;
               else bad = 1'b1;
            end
            ST_EXP_SIGN: begin
               if (dig) st = ST_EXP_DIG;
               else bad = 1'b1;
            end
            ST_INT, ST_PT_AFTER_INT, ST_FRAC, ST_EXP_DIG: begin
               if (dig) begin
                  if (s == ST_PT_AFTER_INT) st = ST_FRAC;
               end else if (pnt && s == ST_INT) begin
                  st = ST_PT_AFTER_INT;
               end else if (exm && s != ST_EXP_DIG) begin
                  st = ST_EXP;
               end else if (spc || cma) begin
                  close_token();
                  tok_open = 1'b0;
                  st = spc ? ST_OUT_COMMA : ST_OUT_NOCOMMA;
               end else if (sgn || pnt) begin
                  // number split without separator
                  close_token();
                  tok_begin = at_pos;
                  st = sgn ? ST_SIGN : ST_PT_LEAD;
               end else begin
                  bad = 1'b1;
               end
            end
            default: bad = 1'b1;
         endcase
         if (bad) stop_parse();
         else if (found_n == want_n) end_parse(1'b1);
         else at_pos = at_pos + 16'd1;
      end
   endtask

   // Idle lengths: mostly short, a few long
   function automatic int idle_length();
      return ($urandom_range(0, 19) < 17) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   // Sender: offers queued items, predicts each one on its transfer
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            tokenize(req_data);
            sent_total++;
         end
         if (push && full) begin
            full_cycles++;
         end else if (send_gap != 0) begin
            send_gap--;
            push <= 1'b0;
         end else if (text_items.size() != 0) begin
            req_data <= text_items.pop_front();
            push <= 1'b1;
            if ((sent_total % 128) >= 96 || $urandom_range(0, 2) != 0) send_gap = 0;
            else send_gap = idle_length();
         end else begin
            push <= 1'b0;
         end
      end
   end

   function automatic bit field_matches(input string name, input int unsigned want,
                                        input int unsigned got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Receiver: checks every transfer against the oldest prediction
   int  pop_hold = 0;
   bit  long_hold_done = 1'b0;
   always @(posedge clock) begin
      rsp_type want;
      bit      ok;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_seen++;
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %p", $time, rsp_data);
               errors++;
            end else begin
               want = results_due.pop_front();
               ok = field_matches("kind", want.kind, rsp_data.kind);
               ok &= field_matches("token_start", want.token_start, rsp_data.token_start);
               ok &= field_matches("token_length", want.token_length, rsp_data.token_length);
               ok &= field_matches("stop_position", want.stop_position,
                                   rsp_data.stop_position);
               ok &= field_matches("numbers_found", want.numbers_found,
                                   rsp_data.numbers_found);
               ok &= field_matches("last", want.last, rsp_data.last);
               if (!ok) errors++;
            end
         end
         if (pop_hold != 0) begin
            pop_hold--;
            pop <= 1'b0;
         end else if (results_seen >= 80 && !long_hold_done) begin
            // long back-pressure: let the block fill and stall its input
            long_hold_done = 1'b1;
            pop_hold = 300;
            pop <= 1'b0;
         end else if ((results_seen % 64) >= 48 || $urandom_range(0, 3) != 0) begin
            pop <= 1'b1;
         end else begin
            pop_hold = idle_length();
            pop <= 1'b0;
         end
      end
   end

   // Stimulus builders; unused fields carry random values
   function automatic req_type noise_item(input cmd_type cmd);
      req_type r;
      r.command = cmd;
      r.char_code = $urandom_range(0, 21'h10FFFF);
      r.start_position = $urandom;
      r.count_wanted = $urandom;
      r.allow_leading_comma = $urandom;
      return r;
   endfunction

   task automatic send_char(input logic [20:0] c);
      req_type r;
      r = noise_item(CMD_CHAR);
      r.char_code = c;
      text_items.push_back(r);
   endtask

   task automatic send_start(input logic [15:0] p, input logic [7:0] n, input logic comma);
      req_type r;
      r = noise_item(CMD_START);
      r.start_position = p;
      r.count_wanted = n;
      r.allow_leading_comma = comma;
      text_items.push_back(r);
   endtask

   task automatic send_cmd(input cmd_type cmd);
      text_items.push_back(noise_item(cmd));
   endtask

   function automatic logic [20:0] pick_space();
      case ($urandom_range(0, 3))
         0: return 21'h09;
         1: return 21'h0a;
         2: return 21'h0d;
         default: return " ";
      endcase
   endfunction

   task automatic send_digits(input int lo, input int hi);
      int n;
      n = $urandom_range(lo, hi);
      repeat (n) send_char(21'h30 + $urandom_range(0, 9));
   endtask

   // One well-formed number: sign, integer/fraction forms, optional exponent
   task automatic send_number();
      int form;
      form = $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) send_char($urandom_range(0, 1) ? "-" : "+");
      if (form != 2) send_digits(1, 3);
      if (form == 1) begin
         send_char(".");
         send_digits(0, 2);
      end
      if (form == 2) begin
         send_char(".");
         send_digits(1, 2);
      end
      if ($urandom_range(0, 3) == 0) begin
         send_char($urandom_range(0, 1) ? "e" : "E");
         if ($urandom_range(0, 1)) send_char($urandom_range(0, 1) ? "-" : "+");
         send_digits(1, 2);
      end
   endtask

   task automatic send_separator();
      case ($urandom_range(0, 5))
         0: send_char(pick_space());
         1: send_char(",");
         2: begin
            send_char(" ");
            send_char(",");
            send_char(pick_space());
         end
         3: repeat ($urandom_range(2, 4)) send_char(pick_space());
         default: ;  // none: relies on a sign or point split, else numbers merge
      endcase
   endtask

   function automatic logic [20:0] pick_bad_char();
      case ($urandom_range(0, 4))
         0: return "x";
         1: return 21'h10FFFF;
         2: return "#";
         3: return 21'h100000 + $urandom_range(0, 21'hFFFF);
         default: return $urandom_range(0, 21'h10FFFF);
      endcase
   endfunction

   // One parse: start, number list or character soup, then an ending
   task automatic send_parse();
      int          sel, n_num, w;
      logic [7:0]  wanted;
      logic [15:0] spos;
      logic        comma;
      sel = $urandom_range(0, 19);
      if (sel < 16) wanted = $urandom_range(0, 5);
      else if (sel < 18) wanted = 8'hFF;
      else wanted = $urandom;
      spos = ($urandom_range(0, 3) == 0) ? 16'hFFF8 + $urandom_range(0, 7) : $urandom;
      comma = $urandom;
      send_start(spos, wanted, comma);
      if ($urandom_range(0, 2) == 0) send_char(pick_space());
      if (comma && $urandom_range(0, 1)) send_char(",");
      if ($urandom_range(0, 7) == 0) begin
         // grammar soup: mostly broken sequences
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 6))
               0: send_char("-");
               1: send_char(".");
               2: send_char("e");
               3: send_char(",");
               4: send_char(pick_space());
               5: send_char("+");
               default: send_digits(1, 1);
            endcase
         end
      end else begin
         w = (wanted > 6) ? $urandom_range(1, 8) : wanted;
         n_num = w + $urandom_range(0, 2) - 1;
         for (int i = 0; i < n_num; i++) begin
            send_number();
            if (i < n_num - 1) send_separator();
         end
      end
      if ($urandom_range(0, 9) == 0) send_cmd(CMD_NOP);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: send_cmd(CMD_END);
         6, 7: send_char(pick_bad_char());
         8: begin
            send_separator();
            send_cmd(CMD_END);
         end
         default: ;  // abandoned by the next start
      endcase
      if ($urandom_range(0, 9) == 0) send_char("7");  // usually hits an idle parser
   endtask

   // Main sequence
   initial begin
      int drain;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle items, wrap, leading comma, split numbers, exponent,
      // non-ASCII, restart, zero count, empty text, unfitting character
      send_char("1");
      send_cmd(CMD_END);
      send_cmd(CMD_NOP);
      send_start(16'hFFFE, 8'd2, 1'b1);
      send_char(",");
      send_char("-");
      send_char("1");
      send_cmd(CMD_NOP);
      send_char(".");
      send_char("5");
      send_char("e");
      send_char("+");
      send_char("3");
      send_char(".");
      send_char("7");
      send_cmd(CMD_END);
      send_start(16'd5, 8'hFF, 1'b0);
      send_char(21'h10FFFF);
      send_start(16'd9, 8'd3, 1'b0);
      send_char("8");
      send_start(16'd0, 8'd0, 1'b0);
      send_char(21'h0);
      send_start(16'hFFFF, 8'd1, 1'b1);
      send_cmd(CMD_END);
      send_start(16'h1234, 8'd1, 1'b0);
      send_char("E");

      // sender pauses until every prediction has been matched
      do @(negedge clock); while (text_items.size() != 0 || push || results_due.size() != 0);

      // Random parses, topped up as the sender drains them
      while (items_used < 550) begin
         @(negedge clock);
         if (text_items.size() < 8) send_parse();
      end

      do @(negedge clock); while (text_items.size() != 0 || push);
      drain = 0;
      while (results_due.size() != 0 && drain < 20000) begin
         @(negedge clock);
         drain++;
      end
      if (results_due.size() != 0) begin
         $display("%0t: %0d results missing, oldest expected %p", $time, results_due.size(),
                  results_due[0]);
         errors++;
      end
      repeat (10) @(posedge clock);

      $display("Covered %0d transfers in (%0d parsed, rest ignored), %0d tokens, %0d ok and",
               sent_total, items_used, n_tokens, n_ok);
      $display("%0d failed parses; input held off by full for %0d cycles, %0d errors.",
               n_fail, full_cycles, errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #1000000;
      $display("%0t: timeout", $time);
      $display("== FAIL ==");
      $finish;
   end

endmodule
